>>> sv/itds_pkg.sv
// Shared types, constants and a helper function for the scaled int-to-double converter.
// No dependencies; every other file refers to it by scoped names.
`timescale 1ns / 1ps

package itds_pkg;

   // IEEE-754 binary64 layout
   localparam int FRAC_BITS   = 52;
   localparam int EXP_BITS    = 11;
   localparam int TOP_BIT     = 63;
   // exponent bias plus the 53-bit significand offset
   localparam int BIAS_LOW    = 1076;
   // low bits of the normalized word folded into the sticky bit
   localparam int STICKY_BITS = 9;
   // biased exponent (minus one) at which the result saturates to infinity
   localparam int EXP_SAT     = 2046;
   // round-up decision indexed by {lsb, guard, sticky}
   localparam logic [7:0] ROUND_TABLE = 8'hC8;

   typedef enum logic [1:0] {
      CLS_ZERO,
      CLS_UNDER,
      CLS_OVER,
      CLS_NORMAL
   } class_type;

   // one classified word waiting for the back end
   typedef struct packed {
      logic                 sign;
      logic [63:0]          mag;
      logic [5:0]           lz;
      logic [EXP_BITS-1:0]  bexp;
      class_type            cls;
   } entry_type;

   // leading-zero count, six halving steps; an all-zero word gives 63
   function automatic logic [5:0] lead_zeros(input logic [63:0] value);
      logic [63:0] v;
      logic [63:0] mask;
      logic [5:0]  n;
      v = value;
      n = '0;
      for (int k = 5; k >= 0; k--) begin
         mask = ~64'd0 << (64 - (1 << k));
         if ((v & mask) == 64'd0) begin
            v    = v << (1 << k);
            n[k] = 1'b1;
         end
      end
      return n;
   endfunction

endpackage

>>> sv/itds_front.sv
// Front end: scale register, sign/magnitude split, leading-zero count and classification.
// Depends on itds_pkg.
`timescale 1ns / 1ps

module itds_front (
   input  logic                clock,
   input  logic                reset,
   input  logic                csr_wen,
   input  logic [11:0]         csr_wdata,
   input  logic [63:0]         req_tdata,   // int_value [63:0]
   output itds_pkg::entry_type entry
);

   logic [11:0]        scale_exp_ff;
   logic               sign;
   logic [63:0]        mag;
   logic [5:0]         lz;
   logic signed [13:0] bexp_wide;

   // scale register
   always_ff @(posedge clock) begin
      if (reset) begin
         scale_exp_ff <= '0;
      end else if (csr_wen) begin
         scale_exp_ff <= csr_wdata;
      end
   end

   // sign, magnitude and exponent before rounding
   always_comb begin
      sign      = req_tdata[itds_pkg::TOP_BIT];
      mag       = sign ? (64'd0 - req_tdata) : req_tdata;
      lz        = itds_pkg::lead_zeros(mag);
      bexp_wide = 14'(itds_pkg::BIAS_LOW + itds_pkg::STICKY_BITS)
                  + {{2{scale_exp_ff[11]}}, scale_exp_ff}
                  - {8'd0, lz};
   end

   // classify
   always_comb begin
      entry.sign = sign;
      entry.mag  = mag;
      entry.lz   = lz;
      entry.bexp = bexp_wide[itds_pkg::EXP_BITS-1:0];
      if (mag == 64'd0) begin
         entry.cls = itds_pkg::CLS_ZERO;
      end else if (bexp_wide < 14'sd0) begin
         entry.cls = itds_pkg::CLS_UNDER;
      end else if (bexp_wide >= 14'(itds_pkg::EXP_SAT)) begin
         entry.cls = itds_pkg::CLS_OVER;
      end else begin
         entry.cls = itds_pkg::CLS_NORMAL;
      end
   end

endmodule

>>> sv/itds_queue.sv
// Short register queue between the front and back ends.
// Depends on itds_pkg.
`timescale 1ns / 1ps

module itds_queue #(
   parameter int DEPTH = 2
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                push,
   input  itds_pkg::entry_type push_entry,
   output logic                full,
   input  logic                pop,
   output logic                head_valid,
   output itds_pkg::entry_type head_entry
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   itds_pkg::entry_type slot_ff [DEPTH];
   logic [PTR_W-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]    count_ff, count_in;

   // pointer and fill bookkeeping
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // payload slots
   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_entry;
      end
   end

   assign full       = (count_ff == CNT_W'(DEPTH));
   assign head_valid = (count_ff != '0);
   assign head_entry = slot_ff[rd_ptr_ff];

   // checks
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(DEPTH))
      else $error("queue fill beyond depth");
   a_count_up: assert property (@(posedge clock) disable iff (reset)
      push && !pop |=> count_ff == $past(count_ff) + 1'b1)
      else $error("queue fill did not rise on push");
   a_count_down: assert property (@(posedge clock) disable iff (reset)
      pop && !push |=> count_ff == $past(count_ff) - 1'b1)
      else $error("queue fill did not fall on pop");
   a_ptr_hold: assert property (@(posedge clock) disable iff (reset)
      !push && !pop |=> $stable(wr_ptr_ff) && $stable(rd_ptr_ff))
      else $error("queue pointers moved while idle");

endmodule

>>> sv/itds_back.sv
// Back end: normalizing shift, sticky/round-to-nearest-even, packing and output register.
// Depends on itds_pkg.
`timescale 1ns / 1ps

module itds_back (
   input  logic                clock,
   input  logic                reset,
   input  logic                head_valid,
   input  itds_pkg::entry_type head_entry,
   output logic                pop,
   output logic                rsp_tvalid,
   input  logic                rsp_tready,
   output logic [63:0]         rsp_tdata    // double_bits [63:0]
);

   logic        rsp_valid_ff, rsp_valid_in;
   logic [63:0] rsp_data_ff, rsp_data_in;
   logic [63:0] norm;
   logic [54:0] sig;
   logic        round_up;
   logic [62:0] body;

   // pop whenever the output register is free or being drained
   assign pop = head_valid && (!rsp_valid_ff || rsp_tready);

   // normalize, fold sticky into the lowest kept bit, round and pack
   always_comb begin
      norm     = head_entry.mag << head_entry.lz;
      sig      = norm[63:itds_pkg::STICKY_BITS] | {54'd0, |norm[itds_pkg::STICKY_BITS-1:0]};
      round_up = itds_pkg::ROUND_TABLE[sig[2:0]];
      body     = {10'd0, sig[54:2]}
                 + {head_entry.bexp, {itds_pkg::FRAC_BITS{1'b0}}}
                 + {62'd0, round_up};
      case (head_entry.cls)
         itds_pkg::CLS_ZERO: begin
            rsp_data_in = '0;
         end
         itds_pkg::CLS_UNDER: begin
            rsp_data_in = {head_entry.sign, 63'd0};
         end
         itds_pkg::CLS_OVER: begin
            rsp_data_in = {head_entry.sign, {itds_pkg::EXP_BITS{1'b1}},
                           {itds_pkg::FRAC_BITS{1'b0}}};
         end
         default: begin
            rsp_data_in = {head_entry.sign, body};
         end
      endcase
   end

   // output valid
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (pop) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule

>>> sv/int_to_double_scaled.sv
// Top level of the scaled int64 to binary64 converter.
// Depends on itds_pkg, itds_front, itds_queue and itds_back.
`timescale 1ns / 1ps
//
// Usage:
//   req_*  : input stream, one 64-bit two's complement integer per word.
//   rsp_*  : result stream, one binary64 bit pattern per input word, in order.
//   csr_*  : write port for the signed 12-bit scale; the value converted is
//            int_value * 2^scale. Write it only while no word is in flight.
// Path: an accepted word is held in two register stages (queue slot, output
//   register) and enters the output register once that register is free.
// Throughput: one word per cycle unless stalled. The front end (negate,
//   leading-zero count, classification) writes the queue in the accept
//   cycle; the back end (normalizing shift, rounding add, packing) drains
//   one entry per cycle. Stall: while rsp_tready is low the output register
//   holds its word and the queue fills; req_tready drops once QUEUE_DEPTH
//   words are buffered and rises again as soon as an entry is drained.
// Reset: synchronous; empties the queue and output register and sets the
//   scale to zero.
//
module int_to_double_scaled #(
   parameter int QUEUE_DEPTH = 2
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_wen,
   input  logic [11:0] csr_wdata,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [63:0] req_tdata,   // int_value [63:0]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [63:0] rsp_tdata    // double_bits [63:0]
);

   itds_pkg::entry_type front_entry;
   itds_pkg::entry_type head_entry;
   logic                push;
   logic                full;
   logic                pop;
   logic                head_valid;

   assign req_tready = !full;
   assign push       = req_tvalid && req_tready;

   // front end
   itds_front u_front (
      .clock     (clock),
      .reset     (reset),
      .csr_wen   (csr_wen),
      .csr_wdata (csr_wdata),
      .req_tdata (req_tdata),
      .entry     (front_entry)
   );

   // decoupling queue
   itds_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (front_entry),
      .full       (full),
      .pop        (pop),
      .head_valid (head_valid),
      .head_entry (head_entry)
   );

   // back end
   itds_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head_valid (head_valid),
      .head_entry (head_entry),
      .pop        (pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

endmodule

>>> tb/sv/int_to_double_scaled_tb.sv
// Self-checking testbench for the scaled int64 to binary64 converter.
// Depends on itds_pkg and int_to_double_scaled; nothing else is read or loaded.
`timescale 1ns / 1ps

module int_to_double_scaled_tb;

   localparam int IDLE_LIMIT = 5000;  // cycles without any handshake before giving up
   localparam int HOLD_CYCLES = 300;  // long result-side stall
   localparam int MAX_GAP = 17;

   logic        clock;
   logic        reset;
   logic        csr_wen;
   logic [11:0] csr_wdata;
   logic        req_tvalid;
   logic        req_tready;
   logic [63:0] req_tdata;   // int_value [63:0]
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [63:0] rsp_tdata;   // double_bits [63:0]

   // predicted binary64 words, oldest first
   logic [63:0] expected_doubles[$];
   logic signed [11:0] scale_setting;
   int error_count;
   bit req_idle_on;
   bit rsp_idle_on;
   bit rsp_hold_request;

   int_to_double_scaled u_top (
      .clock      (clock),
      .reset      (reset),
      .csr_wen    (csr_wen),
      .csr_wdata  (csr_wdata),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // expected encoding of value * 2^scale: round to nearest even, flush to zero, saturate to infinity
   function automatic logic [63:0] int_to_double_bits(input logic [63:0] value,
                                                      input logic signed [11:0] scale);
      logic        sign;
      logic [63:0] mag;
      logic [63:0] norm;
      logic [54:0] sig;
      logic [63:0] word;
      int          lz;
      int          bexp;
      sign = value[63];
      mag  = sign ? (64'd0 - value) : value;
      if (mag == 64'd0) return 64'd0;
      lz = 0;
      while (lz < itds_pkg::TOP_BIT && mag[itds_pkg::TOP_BIT - lz] == 1'b0) lz++;
      norm = mag << lz;
      // 53 significand bits, guard, then sticky folded from the dropped bits
      sig    = norm[63:itds_pkg::STICKY_BITS];
      sig[0] = sig[0] | (|norm[itds_pkg::STICKY_BITS-1:0]);
      bexp   = itds_pkg::STICKY_BITS + int'(scale) - lz + itds_pkg::BIAS_LOW;
      if (bexp < 0) return {sign, 63'd0};
      if (bexp >= itds_pkg::EXP_SAT) return {sign, {itds_pkg::EXP_BITS{1'b1}}, 52'd0};
      word = {sign, 63'd0} | {11'd0, sig[54:2]};
      word = word + (64'(bexp) << itds_pkg::FRAC_BITS)
             + 64'(itds_pkg::ROUND_TABLE[sig[2:0]]);
      return word;
   endfunction

   // random operand, weighted toward short magnitudes and rounding ties
   function automatic logic [63:0] rand_int_value();
      logic [63:0] r;
      logic [63:0] v;
      int          k;
      r = {$urandom, $urandom};
      case ($urandom_range(0, 9))
         0, 1, 2, 3: v = r;
         4, 5: v = r >> $urandom_range(1, 63);
         6, 7: begin
            // exact tie (or near it) at a random position below the significand
            k = $urandom_range(1, 12);
            v = ((r >> $urandom_range(1, 12)) & ~((64'd1 << k) - 64'd1)) | (64'd1 << (k - 1));
            if ($urandom_range(0, 3) == 0) v = v ^ 64'd1;
         end
         8: v = 64'($urandom_range(0, 3));
         default: v = 64'h7FFF_FFFF_FFFF_FFFF - 64'($urandom_range(0, 1023));
      endcase
      if ($urandom_range(0, 1) == 1) v = 64'd0 - v;
      if (v == 64'h8000_0000_0000_0000) v = 64'h8000_0000_0000_0001;
      return v;
   endfunction

   // offer one word, after a random gap when req_idle_on is set; returns at the accepting edge
   task automatic send_int(input logic [63:0] value);
      int gap;
      gap = req_idle_on ? $urandom_range(0, MAX_GAP) : 0;
      @(negedge clock);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= value;
      do @(posedge clock); while (!req_tready);
      expected_doubles.push_back(int_to_double_bits(value, scale_setting));
   endtask

   // stop offering and wait until every predicted word has come back
   task automatic wait_drained();
      @(negedge clock);
      req_tvalid <= 1'b0;
      while (expected_doubles.size() != 0) @(negedge clock);
      repeat (3) @(negedge clock);
   endtask

   // scale write while nothing is in flight
   task automatic set_scale(input logic signed [11:0] scale);
      wait_drained();
      csr_wen       <= 1'b1;
      csr_wdata     <= scale;
      scale_setting  = scale;
      @(negedge clock);
      csr_wen <= 1'b0;
   endtask

   // reset scale of zero: sign, extremes, ties and sticky rounding
   task automatic test_reset_scale();
      req_idle_on = 1'b0;
      rsp_idle_on = 1'b0;
      send_int(64'd0);
      send_int(64'd1);
      send_int(64'd0 - 64'd1);
      send_int(64'h7FFF_FFFF_FFFF_FFFF);
      send_int(64'h8000_0000_0000_0001);
      send_int(64'h0020_0000_0000_0001);   // tie, stays even
      send_int(64'h0020_0000_0000_0003);   // tie, rounds up
      send_int(64'h0040_0000_0000_0003);   // above half, rounds up
      send_int(64'h0040_0000_0000_0001);   // below half, truncates
      send_int(64'h0000_0000_0000_0200);
      send_int(64'h5555_5555_5555_5555);
      send_int(64'hAAAA_AAAA_AAAA_AAAA);
      send_int(64'd0 - 64'h0020_0000_0000_0003);
   endtask

   // extreme scales and the flush-to-zero boundary
   task automatic test_scale_extremes();
      set_scale(12'sd960);
      send_int(64'h7FFF_FFFF_FFFF_FFFF);
      send_int(64'h8000_0000_0000_0001);
      send_int(64'd1);
      set_scale(-12'sd1100);
      send_int(64'h7FFF_FFFF_FFFF_FFFF);
      send_int(64'h8000_0000_0000_0001);
      send_int(64'd0);
      // smallest normal is reached only from a top bit at 62
      set_scale(-12'sd1084);
      send_int(64'h4000_0000_0000_0000);
      send_int(64'hC000_0000_0000_0000);
      send_int(64'h3FFF_FFFF_FFFF_FFFF);   // would round into range, still flushed
      send_int(64'h7FFF_FFFF_FFFF_FFFF);
      send_int(64'd0 - 64'd1);
      set_scale(-12'sd1085);
      send_int(64'h4000_0000_0000_0000);
   endtask

   // random operands across a series of scale settings
   task automatic test_random_scales();
      logic signed [11:0] scale;
      for (int phase = 0; phase < 6; phase++) begin
         case (phase)
            0: scale = 12'sd960;
            1: scale = -12'sd1100;
            2: scale = 12'($signed($urandom_range(0, 80)) - 1120 + 20);
            default: scale = 12'($signed($urandom_range(0, 2060)) - 1100);
         endcase
         set_scale(scale);
         req_idle_on = (phase != 3);
         rsp_idle_on = (phase != 4);
         for (int n = 0; n < 270; n++) send_int(rand_int_value());
      end
   endtask

   // receiver stalls for a long stretch while words keep coming
   task automatic test_output_stall();
      wait_drained();
      req_idle_on      = 1'b0;
      rsp_idle_on      = 1'b1;
      rsp_hold_request = 1'b1;
      for (int n = 0; n < 40; n++) send_int(rand_int_value());
      wait_drained();
   endtask

   // result-side ready with random gaps when rsp_idle_on is set and a long hold on request
   initial begin
      int gap;
      rsp_tready = 1'b0;
      forever begin
         @(negedge clock);
         if (rsp_hold_request) begin
            rsp_hold_request = 1'b0;
            rsp_tready <= 1'b0;
            repeat (HOLD_CYCLES) @(negedge clock);
         end
         gap = rsp_idle_on ? $urandom_range(0, MAX_GAP) : 0;
         if (gap > 0) begin
            rsp_tready <= 1'b0;
            repeat (gap) @(negedge clock);
         end
         rsp_tready <= 1'b1;
         do @(posedge clock); while (!rsp_tvalid);
      end
   end

   // compare each result word with the oldest prediction
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (expected_doubles.size() == 0) begin
            error_count++;
            $display("%0t: unexpected result word, expected none actual %h", $time, rsp_tdata);
         end else if (rsp_tdata !== expected_doubles[0]) begin
            error_count++;
            $display("%0t: double_bits mismatch, expected %h actual %h",
                     $time, expected_doubles[0], rsp_tdata);
            void'(expected_doubles.pop_front());
         end else begin
            void'(expected_doubles.pop_front());
         end
      end
   end

   // watchdog on cycles with no handshake at all
   initial begin
      int idle_cycles;
      idle_cycles = 0;
      while (idle_cycles < IDLE_LIMIT) begin
         @(posedge clock);
         if (reset || csr_wen || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready))
            idle_cycles = 0;
         else
            idle_cycles++;
      end
      $display("Verification failed");
      $finish;
   end

   initial begin
      reset            = 1'b1;
      csr_wen          = 1'b0;
      csr_wdata        = '0;
      req_tvalid       = 1'b0;
      req_tdata        = '0;
      scale_setting    = '0;
      error_count      = 0;
      req_idle_on      = 1'b0;
      rsp_idle_on      = 1'b0;
      rsp_hold_request = 1'b0;
      repeat (2) @(negedge clock);
      reset <= 1'b0;
      test_reset_scale();
      test_scale_extremes();
      test_random_scales();
      test_output_stall();
      wait_drained();
      repeat (8) @(negedge clock);
      if (expected_doubles.size() != 0) begin
         error_count++;
         $display("%0t: %0d result words never arrived", $time, expected_doubles.size());
      end
      if (error_count == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule
